// File: hdl/brfc_pkg.sv
// Shared types and constants of the allocation bitmap block.
package brfc_pkg;

    localparam int WORD_BITS       = 32;
    localparam int LSB_W           = 5;
    localparam int BITMAP_BITS_DEF = 32768;
    // Word counters reach one past the last word a free request can touch.
    localparam int WW              = 12;
    // Bit positions reach the exclusive end of the widest free range.
    localparam int BW              = 17;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_FREE = 2'd1;
    localparam logic [1:0] REQ_FIND = 2'd2;

    localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // Inclusive bit span inside one word.
    typedef struct packed {
        logic [LSB_W-1:0] lo;
        logic [LSB_W-1:0] hi;
    } range_t;

    // Lowest clear bit inside the span.
    typedef struct packed {
        logic             hit;
        logic [LSB_W-1:0] pos;
    } find_t;

endpackage

// File: hdl/brfc_word_unit.sv
// Word unit: masks one bitmap word to a span, clears it and finds its lowest free bit.
module brfc_word_unit (
    input  logic [brfc_pkg::WORD_BITS-1:0] rd_word,
    input  brfc_pkg::range_t               rng,
    output logic [brfc_pkg::WORD_BITS-1:0] clr_word,
    output brfc_pkg::find_t                fres
);
    import brfc_pkg::*;

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bits;

    assign mask      = (ALL_ONES << rng.lo) & (ALL_ONES >> (LSB_W'(WORD_BITS - 1) - rng.hi));
    assign free_bits = ~rd_word & mask;
    assign clr_word  = rd_word & ~mask;

    always_comb begin
        fres.hit = |free_bits;
        fres.pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                fres.pos = LSB_W'(i);
            end
        end
    end

endmodule

// File: hdl/bitmap_range_free_find_clear_top.sv
// Allocation bitmap with word load, range free and first-free-bit search.
//
// Input channel s_*: one request per beat (load word, free range, find clear bit).
// Result channel m_*: exactly one result beat per request; m_found and
// m_bit_index are zero for everything but a successful find.
// A load passes from acceptance through the ST_POST state to its result. A free or
// find walks the bitmap memory one word per cycle through a single
// read-modify-write word unit; a find stops at the first word holding a free
// bit. The full range is 1024 words for a find and up to 2048 for a free.
// One request is in work at a time; the next is accepted once the previous one
// has handed its result to the output register.
// After reset a clearing pass writes zero to every memory word, one word per
// cycle (min(ceil(BITMAP_BITS/32), 2048) words), and s_ready stays low during it.
// When the receiver stalls, the result is held in the output register; one
// further request may be accepted and processed, and it waits for the output
// register to empty before it completes.
module bitmap_range_free_find_clear_top #(
    parameter int BITMAP_BITS = brfc_pkg::BITMAP_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [9:0]  s_word_index,
    input  logic [31:0] s_word_data,
    input  logic [14:0] s_start_bit,
    input  logic [15:0] s_bit_count,
    input  logic [15:0] s_end_bit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [14:0] m_bit_index
);
    import brfc_pkg::*;

    localparam int NUM_WORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int MEM_WORDS = (NUM_WORDS < 2048) ? NUM_WORDS : 2048;
    localparam int AW        = $clog2(MEM_WORDS);
    localparam logic [BW-1:0] LIM_FREE  = BW'((BITMAP_BITS < 65536) ? BITMAP_BITS : 65536);
    localparam logic [BW-1:0] LIM_FIND  = BW'((BITMAP_BITS < 32768) ? BITMAP_BITS : 32768);
    localparam logic [BW-1:0] NUM_WORDS_V = BW'(NUM_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FREE  = 3'd2;
    localparam logic [2:0] ST_FIND  = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;

    logic [WORD_BITS-1:0] mem [MEM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [WW-1:0]    issue_addr_reg, issue_addr_next;
    logic [WW-1:0]    first_reg, first_next;
    logic [WW-1:0]    last_reg, last_next;
    logic [LSB_W-1:0] lo_reg, lo_next;
    logic [LSB_W-1:0] hi_reg, hi_next;
    logic             p_vld_reg, p_vld_next;
    logic [WW-1:0]    p_addr_reg, p_addr_next;
    logic             res_found_reg, res_found_next;
    logic [14:0]      res_idx_reg, res_idx_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [14:0]      m_idx_reg, m_idx_next;

    logic             accept;
    logic [BW-1:0]    start_ext, sum_free, end_free, end_find_in, end_find, end_sel, last_bit;
    logic             empty_rng;
    logic [WW-1:0]    widx_ext;
    logic             issue;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    range_t               rng;
    logic [WORD_BITS-1:0] clr_word;
    find_t                fres;

    brfc_word_unit u_word (
        .rd_word  (rd_data_reg),
        .rng      (rng),
        .clr_word (clr_word),
        .fres     (fres)
    );

    assign accept      = s_valid && s_ready;
    assign start_ext   = BW'(s_start_bit);
    assign sum_free    = start_ext + BW'(s_bit_count);
    assign end_free    = (sum_free > LIM_FREE) ? LIM_FREE : sum_free;
    assign end_find_in = BW'(s_end_bit);
    assign end_find    = (end_find_in > LIM_FIND) ? LIM_FIND : end_find_in;
    assign end_sel     = (s_req_type == REQ_FREE) ? end_free : end_find;
    assign empty_rng   = (start_ext >= end_sel);
    assign last_bit    = end_sel - BW'(1);
    assign widx_ext    = WW'(s_word_index);

    assign issue = ((state_reg == ST_FREE) || (state_reg == ST_FIND)) &&
                   (issue_addr_reg <= last_reg);

    assign rng.lo = (p_addr_reg == first_reg) ? lo_reg : '0;
    assign rng.hi = (p_addr_reg == last_reg) ? hi_reg : LSB_W'(WORD_BITS - 1);

    // Memory write source: clearing pass, word load or free write-back.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = widx_ext[AW-1:0];
        wr_data = s_word_data;
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else if (state_reg == ST_FREE) begin
            wr_en   = p_vld_reg;
            wr_addr = p_addr_reg[AW-1:0];
            wr_data = clr_word;
        end else if (accept && (s_req_type == REQ_LOAD)) begin
            wr_en = (BW'(s_word_index) < NUM_WORDS_V);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[issue_addr_reg[AW-1:0]];
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        issue_addr_next = issue_addr_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        p_vld_next      = issue;
        p_addr_next     = issue_addr_reg;
        res_found_next  = res_found_reg;
        res_idx_next    = res_idx_reg;
        m_valid_next    = m_valid_reg;
        m_found_next    = m_found_reg;
        m_idx_next      = m_idx_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (issue) begin
            issue_addr_next = issue_addr_reg + WW'(1);
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_found_next  = 1'b0;
                    res_idx_next    = '0;
                    first_next      = WW'(s_start_bit[14:LSB_W]);
                    last_next       = last_bit[BW-1:LSB_W];
                    issue_addr_next = WW'(s_start_bit[14:LSB_W]);
                    lo_next         = s_start_bit[LSB_W-1:0];
                    hi_next         = last_bit[LSB_W-1:0];
                    if ((s_req_type == REQ_FREE) && !empty_rng) begin
                        state_next = ST_FREE;
                    end else if ((s_req_type == REQ_FIND) && !empty_rng) begin
                        state_next = ST_FIND;
                    end else begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_FREE: begin
                if (p_vld_reg && (p_addr_reg == last_reg)) begin
                    state_next = ST_POST;
                end
            end
            ST_FIND: begin
                if (p_vld_reg && fres.hit) begin
                    res_found_next = 1'b1;
                    res_idx_next   = {p_addr_reg[9:0], fres.pos};
                    state_next     = ST_POST;
                end else if (p_vld_reg && (p_addr_reg == last_reg)) begin
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                // Wait here while the previous result is still held downstream.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_idx_next   = res_idx_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            p_vld_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            p_vld_reg    <= p_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_addr_reg <= issue_addr_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        p_addr_reg     <= p_addr_next;
        res_found_reg  <= res_found_next;
        res_idx_reg    <= res_idx_next;
        m_found_reg    <= m_found_next;
        m_idx_reg      <= m_idx_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_bit_index = m_idx_reg;

endmodule

// File: hdl/brfc_checker.sv
// Port-level checks of the allocation bitmap block, bound to its top level.
module brfc_port_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [14:0] m_bit_index
);

    // A held result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_bit_index))
        else $error("result beat changed while stalled");

    // A result without a found bit always reports index zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_bit_index == 15'd0)
        else $error("not-found result with nonzero index");

    // The clearing pass after reset keeps the input closed.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    // Only one request is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted beat");

endmodule

bind bitmap_range_free_find_clear_top brfc_port_props u_brfc_port_props (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_found     (m_found),
    .m_bit_index (m_bit_index)
);
